// ===== rtl/core/lift_homing_sequencer_defines.svh =====
// assertion macros shared by the lift homing sequencer checkers
// no dependencies; include by bare file name inside a module or file scope
`ifndef LIFT_HOMING_SEQUENCER_DEFINES_SVH
`define LIFT_HOMING_SEQUENCER_DEFINES_SVH

// property checked outside reset only
`define LHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define LHS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/lhs_pkg.sv =====
// shared types, codes and reset constants for the lift homing sequencer
// no dependencies; imported by every rtl module of the block
package lhs_pkg;

  localparam int CfgW             = 16;
  localparam int CfgIdxW          = 2;
  localparam int DelayBitsDefault = 16;

  localparam logic [CfgW-1:0] SettleReset = 16'd1000;
  localparam logic [CfgW-1:0] IndexReset  = 16'd2000;
  localparam logic [CfgW-1:0] BrakeReset  = 16'd20;
  localparam logic [CfgW-1:0] AbortReset  = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETTLE = 2'd0,
    REG_INDEX  = 2'd1,
    REG_BRAKE  = 2'd2,
    REG_ABORT  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    SITE_UNKNOWN = 2'd0,
    SITE_UPPER   = 2'd1,
    SITE_LOWER   = 2'd2,
    SITE_BETWEEN = 2'd3
  } site_e;

  typedef enum logic [1:0] {
    MOVE_NONE = 2'd0,
    MOVE_UP   = 2'd1,
    MOVE_DOWN = 2'd2
  } move_e;

  typedef enum logic [7:0] {
    STEP_IDLE       = 8'b0000_0001,
    STEP_SEEK       = 8'b0000_0010,
    STEP_DRIVE_DOWN = 8'b0000_0100,
    STEP_SETTLE     = 8'b0000_1000,
    STEP_DRIVE_UP   = 8'b0001_0000,
    STEP_STOP_ZERO  = 8'b0010_0000,
    STEP_INDEX_WAIT = 8'b0100_0000,
    STEP_BRAKE      = 8'b1000_0000
  } step_e;

  typedef struct packed {
    logic [CfgW-1:0] settle;
    logic [CfgW-1:0] index;
    logic [CfgW-1:0] brake;
    logic [CfgW-1:0] abort;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       upper;
    logic       lower;
  } item_t;

  // refused sits in the lowest bit
  typedef struct packed {
    logic [2:0] step;
    logic [1:0] site;
    logic       scanning;
    logic       zero;
    logic [1:0] move_dir;
    logic       jog_stop;
    logic       estop;
    logic       refused;
  } result_t;

  localparam int ResultW = $bits(result_t);
  localparam int OutDataW = ((ResultW + 7) / 8) * 8;

  function automatic logic [2:0] step_code(step_e s);
    logic [2:0] c;
    unique case (s)
      STEP_IDLE:       c = 3'd0;
      STEP_SEEK:       c = 3'd1;
      STEP_DRIVE_DOWN: c = 3'd2;
      STEP_SETTLE:     c = 3'd3;
      STEP_DRIVE_UP:   c = 3'd4;
      STEP_STOP_ZERO:  c = 3'd5;
      STEP_INDEX_WAIT: c = 3'd6;
      STEP_BRAKE:      c = 3'd7;
      default:         c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/lhs_cfg_regs.sv =====
// configuration register bank: settle, index, brake and abort brake delays
// depends on lhs_pkg
module lhs_cfg_regs import lhs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SETTLE: cfg_d.settle = cfg_wdata_i;
        REG_INDEX:  cfg_d.index  = cfg_wdata_i;
        REG_BRAKE:  cfg_d.brake  = cfg_wdata_i;
        REG_ABORT:  cfg_d.abort  = cfg_wdata_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle <= SettleReset;
      cfg_q.index  <= IndexReset;
      cfg_q.brake  <= BrakeReset;
      cfg_q.abort  <= AbortReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/lhs_core.sv =====
// position tracking and homing step logic with its state registers
// depends on lhs_pkg; state advances on the fire strobe from the top level
module lhs_core import lhs_pkg::*; #(
  parameter int DELAY_BITS = DelayBitsDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam int ExtW = (DELAY_BITS > CfgW) ? DELAY_BITS : CfgW;

  function automatic logic [DELAY_BITS-1:0] fit_delay(logic [CfgW-1:0] v);
    logic [ExtW-1:0] w;
    w = ExtW'(v);
    return w[DELAY_BITS-1:0];
  endfunction

  site_e                 site_q, site_d;
  step_e                 step_q, step_d;
  logic                  scan_q, scan_d;
  logic [DELAY_BITS-1:0] cnt_q, cnt_d;

  logic [DELAY_BITS-1:0] cnt_dec;
  logic                  cnt_done;
  logic                  refused, estop, jstop, zero;
  move_e                 dir;

  // wait ends on the tick where the count is or reaches zero
  assign cnt_dec  = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
  assign cnt_done = (cnt_dec == '0);

  always_comb begin
    site_d  = site_q;
    step_d  = step_q;
    scan_d  = scan_q;
    cnt_d   = cnt_q;
    refused = 1'b0;
    estop   = 1'b0;
    jstop   = 1'b0;
    zero    = 1'b0;
    dir     = MOVE_NONE;
    unique case (item_i.cmd)
      CMD_START: begin
        if (step_q == STEP_IDLE) step_d = STEP_SEEK;
        else refused = 1'b1;
      end
      CMD_STOP: begin
        step_d = STEP_BRAKE;
        jstop  = 1'b1;
        cnt_d  = fit_delay(cfg_i.abort);
      end
      CMD_TICK: begin
        // both switches active count as the upper limit
        if (site_q == SITE_UNKNOWN) begin
          site_d = item_i.upper ? SITE_UPPER : (item_i.lower ? SITE_LOWER : SITE_BETWEEN);
        end else if (item_i.upper) begin
          site_d = SITE_UPPER;
          estop  = (site_q != SITE_UPPER);
        end else if (item_i.lower) begin
          site_d = SITE_LOWER;
          estop  = (site_q != SITE_LOWER);
        end else begin
          site_d = SITE_BETWEEN;
        end

        unique case (step_q)
          STEP_IDLE: ;
          STEP_SEEK: begin
            scan_d = 1'b1;
            if (site_d == SITE_LOWER) begin
              step_d = STEP_DRIVE_UP;
              dir    = MOVE_UP;
            end else begin
              step_d = STEP_DRIVE_DOWN;
              dir    = MOVE_DOWN;
            end
          end
          STEP_DRIVE_DOWN: begin
            if (site_d == SITE_LOWER) begin
              step_d = STEP_SETTLE;
              cnt_d  = fit_delay(cfg_i.settle);
            end
          end
          STEP_SETTLE: begin
            cnt_d = cnt_dec;
            if (cnt_done) begin
              step_d = STEP_DRIVE_UP;
              dir    = MOVE_UP;
            end
          end
          STEP_DRIVE_UP: begin
            if (site_d == SITE_BETWEEN) step_d = STEP_STOP_ZERO;
          end
          STEP_STOP_ZERO: begin
            step_d = STEP_INDEX_WAIT;
            jstop  = 1'b1;
            zero   = 1'b1;
            cnt_d  = fit_delay(cfg_i.index);
          end
          STEP_INDEX_WAIT: begin
            cnt_d = cnt_dec;
            if (cnt_done) begin
              step_d = STEP_BRAKE;
              zero   = 1'b1;
              cnt_d  = fit_delay(cfg_i.brake);
            end
          end
          STEP_BRAKE: begin
            cnt_d = cnt_dec;
            if (cnt_done) begin
              step_d = STEP_IDLE;
              scan_d = 1'b0;
            end
          end
          default: step_d = step_q;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_q <= SITE_UNKNOWN;
      step_q <= STEP_IDLE;
      scan_q <= 1'b0;
      cnt_q  <= '0;
    end else if (fire_i) begin
      site_q <= site_d;
      step_q <= step_d;
      scan_q <= scan_d;
      cnt_q  <= cnt_d;
    end
  end

  always_comb begin
    result_o.step     = step_code(step_d);
    result_o.site     = site_d;
    result_o.scanning = scan_d;
    result_o.zero     = zero;
    result_o.move_dir = dir;
    result_o.jog_stop = jstop;
    result_o.estop    = estop;
    result_o.refused  = refused;
  end

endmodule

// ===== rtl/core/lift_homing_sequencer.sv =====
// Lift homing sequencer.
// Slave stream: one word per tick or request. tuser carries the command
// (tick, start homing, stop homing); tdata carries the limit switch levels.
// Master stream: one result word per accepted input word, in order, with
// the strobes of that item (refused, emergency stop, jog stop, move
// direction, zero position) and the state after it (scanning flag,
// platform site, homing step).
// Configuration: write enable, register index and 16 bit data for the
// settle, index, brake and abort brake delays; write only while idle.
// Each word passes one input register stage, then the tracking and homing step
// logic into the result register. Throughput is one word per cycle while the
// receiver takes every result, as the homing step register and delay counter
// update on each accepted word.
// When the receiver stalls the result register holds and the input stage
// holds the next word; tready drops only when both are full.
// Reset clears the state to unknown site, idle step, scanning off, count
// zero, the delay registers to their defaults, and empties both stages.
module lift_homing_sequencer import lhs_pkg::*; #(
  parameter int DELAY_BITS = DelayBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // upper_switch, lower_switch
  input  logic [1:0]          s_axis_tuser,   // cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // refused, emergency_stop, jog_stop, move_dir, zero_position, scanning,
  // platform_site, step_now
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i
);

  cfg_t    cfg;
  result_t result;
  item_t   item_q;
  logic    in_valid_q, in_valid_d;
  result_t out_q;
  logic    out_valid_q, out_valid_d;
  logic    fire;

  lhs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lhs_core #(
    .DELAY_BITS (DELAY_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) in_valid_d = 1'b1;
    else if (fire) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (fire) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.cmd   <= s_axis_tuser;
      item_q.upper <= s_axis_tdata[0];
      item_q.lower <= s_axis_tdata[1];
    end
    if (fire) out_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);

endmodule

// ===== rtl/core/lhs_checker.sv =====
// port-level checks of the lift homing sequencer, bound to the top level
// depends on lhs_pkg and lift_homing_sequencer_defines.svh
`include "lift_homing_sequencer_defines.svh"

module lhs_checker import lhs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  result_t res_w;
  logic    idle_w;
  logic    at_limit_w;
  logic    stall_w;
  logic    busy_w;

  assign res_w      = result_t'(m_axis_tdata[ResultW-1:0]);
  assign idle_w     = (res_w.step == step_code(STEP_IDLE));
  assign at_limit_w = (res_w.site == SITE_UPPER) || (res_w.site == SITE_LOWER);
  assign stall_w    = m_axis_tvalid && !m_axis_tready;
  // a refused start leaves a busy step and starts no move
  assign busy_w     = !idle_w && (res_w.move_dir == MOVE_NONE);

  `LHS_ASSERT_RST(a_no_valid_in_reset, !rst_ni |-> !m_axis_tvalid, "result valid during reset")
  `LHS_ASSERT(a_stall_hold, stall_w |=> m_axis_tvalid && $stable(m_axis_tdata), "word changed")
  `LHS_ASSERT(a_idle_not_scanning, m_axis_tvalid && idle_w |-> !res_w.scanning, "idle scanning")
  `LHS_ASSERT(a_estop_at_limit, m_axis_tvalid && res_w.estop |-> at_limit_w, "estop off limit")
  `LHS_ASSERT(a_refused_busy, m_axis_tvalid && res_w.refused |-> busy_w, "refused while idle")

endmodule

bind lift_homing_sequencer lhs_checker u_lhs_checker (.*);

// ===== tb/tb_lift_homing_sequencer.sv =====
// self-checking bench for the lift homing sequencer: queue-fed stream driver,
// result monitor with a word-level homing predictor, random idling on both sides
// depends on lhs_pkg and the lift_homing_sequencer rtl
module tb_lift_homing_sequencer;
  import lhs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DelayW    = DelayBitsDefault;
  localparam int StallLimit = 2000;
  localparam int MaxReports = 100;

  // homing step codes as reported in step_now
  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_SEEK       = 3'd1;
  localparam logic [2:0] ST_DRIVE_DOWN = 3'd2;
  localparam logic [2:0] ST_SETTLE     = 3'd3;
  localparam logic [2:0] ST_DRIVE_UP   = 3'd4;
  localparam logic [2:0] ST_STOP_ZERO  = 3'd5;
  localparam logic [2:0] ST_INDEX_WAIT = 3'd6;
  localparam logic [2:0] ST_BRAKE      = 3'd7;
  localparam logic [1:0] CMD_NOP       = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // upper_switch, lower_switch
  logic [1:0]          s_axis_tuser = '0;   // cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // refused, emergency_stop, jog_stop, move_dir, zero_position, scanning,
  // platform_site, step_now
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;

  lift_homing_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  item_t   pending_words[$];
  result_t due_results[$];
  item_t   next_word;
  item_t   taken_word;

  // predictor state and register copies
  cfg_t              delays;
  site_e             pos_site;
  logic [2:0]        seq_step;
  logic              seq_scan;
  logic [DelayW-1:0] wait_cnt;

  int  err_cnt = 0;
  int  n_items = 0;
  int  send_gap = 0;
  int  recv_hold = 0;
  int  quiet_cycles = 0;
  bit  quiet = 1'b0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  // true on the waiting tick where the count is or becomes zero
  function automatic bit count_down();
    if (wait_cnt != '0) wait_cnt = wait_cnt - 1'b1;
    return wait_cnt == '0;
  endfunction

  function automatic result_t homing_next(item_t w);
    result_t r;
    r = '0;
    case (w.cmd)
      CMD_START: begin
        if (seq_step == ST_IDLE) seq_step = ST_SEEK;
        else r.refused = 1'b1;
      end
      CMD_STOP: begin
        seq_step   = ST_BRAKE;
        r.jog_stop = 1'b1;
        wait_cnt   = delays.abort;
      end
      CMD_TICK: begin
        // tracking first; both switches read as the upper limit
        if (pos_site == SITE_UNKNOWN) begin
          pos_site = w.upper ? SITE_UPPER : (w.lower ? SITE_LOWER : SITE_BETWEEN);
        end else if (w.upper) begin
          if (pos_site != SITE_UPPER) begin
            pos_site = SITE_UPPER;
            r.estop  = 1'b1;
          end
        end else if (w.lower) begin
          if (pos_site != SITE_LOWER) begin
            pos_site = SITE_LOWER;
            r.estop  = 1'b1;
          end
        end else begin
          pos_site = SITE_BETWEEN;
        end
        case (seq_step)
          ST_SEEK: begin
            seq_scan = 1'b1;
            if (pos_site == SITE_LOWER) begin
              seq_step   = ST_DRIVE_UP;
              r.move_dir = MOVE_UP;
            end else begin
              seq_step   = ST_DRIVE_DOWN;
              r.move_dir = MOVE_DOWN;
            end
          end
          ST_DRIVE_DOWN: begin
            if (pos_site == SITE_LOWER) begin
              seq_step = ST_SETTLE;
              wait_cnt = delays.settle;
            end
          end
          ST_SETTLE: begin
            if (count_down()) begin
              seq_step   = ST_DRIVE_UP;
              r.move_dir = MOVE_UP;
            end
          end
          ST_DRIVE_UP: begin
            if (pos_site == SITE_BETWEEN) seq_step = ST_STOP_ZERO;
          end
          ST_STOP_ZERO: begin
            seq_step   = ST_INDEX_WAIT;
            r.jog_stop = 1'b1;
            r.zero     = 1'b1;
            wait_cnt   = delays.index;
          end
          ST_INDEX_WAIT: begin
            if (count_down()) begin
              seq_step = ST_BRAKE;
              r.zero   = 1'b1;
              wait_cnt = delays.brake;
            end
          end
          ST_BRAKE: begin
            if (count_down()) begin
              seq_step = ST_IDLE;
              seq_scan = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;  // fourth command code leaves everything alone
    endcase
    r.scanning = seq_scan;
    r.site     = pos_site;
    r.step     = seq_step;
    return r;
  endfunction

  task automatic field_check(string f, logic [2:0] e, logic [2:0] a);
    if (a !== e) begin
      err_cnt++;
      if (err_cnt <= MaxReports)
        $display("%0t ns mismatch %s: expected %0d actual %0d", $time, f, e, a);
    end
  endtask

  task automatic check_word(result_t e, result_t a);
    field_check("refused", e.refused, a.refused);
    field_check("emergency_stop", e.estop, a.estop);
    field_check("jog_stop", e.jog_stop, a.jog_stop);
    field_check("move_dir", e.move_dir, a.move_dir);
    field_check("zero_position", e.zero, a.zero);
    field_check("scanning", e.scanning, a.scanning);
    field_check("platform_site", e.site, a.site);
    field_check("step_now", e.step, a.step);
  endtask

  // sender: a new word only once the previous one was taken
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_took) begin
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pending_words.size() > 0) begin
        next_word = pending_words.pop_front();
        s_axis_tuser  <= next_word.cmd;
        s_axis_tdata  <= {6'b0, next_word.lower, next_word.upper};
        s_axis_tvalid <= 1'b1;
        send_gap = draw_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: a random stall, possibly none, after each result word
  always @(negedge clk_i) begin
    if (out_took) recv_hold = draw_gap();
    if (recv_hold > 0) begin
      m_axis_tready <= 1'b0;
      recv_hold = recv_hold - 1;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    in_took  <= s_axis_tvalid && s_axis_tready === 1'b1;
    out_took <= m_axis_tvalid === 1'b1 && m_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready === 1'b1) begin
        taken_word.cmd   = s_axis_tuser;
        taken_word.upper = s_axis_tdata[0];
        taken_word.lower = s_axis_tdata[1];
        due_results.push_back(homing_next(taken_word));
      end
      if (m_axis_tvalid !== 1'b0 && m_axis_tready) begin
        if (due_results.size() == 0) begin
          err_cnt++;
          $display("%0t ns unexpected result word: expected none actual %h",
                   $time, m_axis_tdata);
        end else begin
          check_word(due_results.pop_front(), result_t'(m_axis_tdata[ResultW-1:0]));
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t ns watchdog: no handshake for %0d cycles", $time, StallLimit);
        $display("** lift_homing_sequencer: FAILED **");
        $finish;
      end
    end
  end

  task automatic push_word(logic [1:0] cmd, logic up, logic dn);
    item_t w;
    w.cmd   = cmd;
    w.upper = up;
    w.lower = dn;
    pending_words.push_back(w);
    if (cmd != CMD_NOP) n_items++;
  endtask

  task automatic push_ticks(int n, logic up, logic dn);
    repeat (n) push_word(CMD_TICK, up, dn);
  endtask

  // random words; mostly ticks unless only ticks are wanted
  task automatic push_noise(int n, bit ticks_only);
    int r;
    logic [1:0] c;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (ticks_only || r < 80) c = CMD_TICK;
      else if (r < 88) c = CMD_START;
      else if (r < 96) c = CMD_STOP;
      else c = CMD_NOP;
      push_word(c, $urandom_range(0, 1), $urandom_range(0, 1));
    end
  endtask

  // a plausible homing pass: down to the lower limit, settle, up and off it
  task automatic homing_run();
    if ($urandom_range(0, 1)) push_ticks($urandom_range(1, 3), 1'b1, $urandom_range(0, 1));
    push_word(CMD_START, $urandom_range(0, 1), $urandom_range(0, 1));
    push_ticks($urandom_range(1, 4), 1'b0, 1'b0);
    push_ticks(delays.settle + $urandom_range(0, 3), 1'b0, 1'b1);
    if ($urandom_range(0, 3) == 0) push_noise(1, 1'b0);
    push_ticks(delays.index + delays.brake + $urandom_range(2, 6), 1'b0, 1'b0);
  endtask

  task automatic stop_and_wait();
    push_word(CMD_STOP, $urandom_range(0, 1), $urandom_range(0, 1));
    push_noise(delays.abort + 1, 1'b1);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SETTLE: delays.settle = val;
      REG_INDEX:  delays.index  = val;
      REG_BRAKE:  delays.brake  = val;
      REG_ABORT:  delays.abort  = val;
      default: ;
    endcase
  endtask

  task automatic set_delays(int s, int i, int b, int a);
    write_reg(REG_SETTLE, CfgW'(s));
    write_reg(REG_INDEX, CfgW'(i));
    write_reg(REG_BRAKE, CfgW'(b));
    write_reg(REG_ABORT, CfgW'(a));
  endtask

  // block is idle once every word is sent and every result is back
  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_words.size() != 0 || s_axis_tvalid || due_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic int pick_delay();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
  endfunction

  initial begin
    int target;
    int r;
    delays   = '{settle: SettleReset, index: IndexReset, brake: BrakeReset,
                 abort: AbortReset};
    pos_site = SITE_UNKNOWN;
    seq_step = ST_IDLE;
    seq_scan = 1'b0;
    wait_cnt = '0;
    #1;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part on the reset delays
    push_word(CMD_START, 1'b1, 1'b1);   // start while site unknown, switches ignored
    push_word(CMD_NOP, 1'b1, 1'b0);
    push_word(CMD_TICK, 1'b1, 1'b1);    // first tick, both switches: upper, no estop
    push_word(CMD_START, 1'b0, 1'b0);   // refused while busy
    push_word(CMD_TICK, 1'b1, 1'b0);
    push_word(CMD_TICK, 1'b0, 1'b0);
    push_word(CMD_TICK, 1'b0, 1'b1);    // arrival at lower limit
    push_word(CMD_TICK, 1'b1, 1'b1);
    push_word(CMD_TICK, 1'b0, 1'b1);
    push_word(CMD_TICK, 1'b1, 1'b0);
    push_word(CMD_STOP, 1'b1, 1'b1);
    push_word(CMD_START, 1'b0, 1'b1);
    push_ticks(20, 1'b0, 1'b0);         // still braking on the default abort count
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_delays(1, 1, 1, 1);
        1: set_delays(2, 3, 1, 2);
        default: set_delays(pick_delay(), pick_delay(), pick_delay(), pick_delay());
      endcase
      quiet  = ($urandom_range(0, 3) == 0);
      target = n_items + 110;
      while (n_items < target) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          homing_run();
        end else if (r < 75) begin
          push_noise($urandom_range(1, 8), 1'b0);
        end else if (r < 90) begin
          stop_and_wait();
        end else begin
          // homing broken off part way
          push_word(CMD_START, 1'b0, 1'b0);
          push_noise($urandom_range(1, 6), 1'b1);
          stop_and_wait();
        end
      end
      drain();
    end

    // widest counts: each long wait is entered and then cut short by a stop
    set_delays(16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
    quiet = 1'b1;
    push_word(CMD_STOP, 1'b0, 1'b0);
    push_ticks(2, 1'b0, 1'b1);          // brake over, resting on the lower limit
    push_word(CMD_START, 1'b0, 1'b0);
    push_ticks(2, 1'b0, 1'b1);          // seek goes straight to drive up
    push_ticks(60, 1'b0, 1'b0);         // off the limit, into index wait with the full count
    push_word(CMD_STOP, 1'b0, 1'b0);
    push_ticks(2, 1'b0, 1'b0);
    push_word(CMD_START, 1'b0, 1'b0);
    push_ticks(3, 1'b0, 1'b0);
    push_ticks(60, 1'b0, 1'b1);         // settle with the full count
    drain();
    write_reg(REG_ABORT, 16'hFFFF);
    push_word(CMD_STOP, 1'b0, 1'b0);
    push_ticks(60, 1'b0, 1'b0);
    drain();

    set_delays(1, 1, 1, 1);
    quiet = 1'b0;
    push_word(CMD_STOP, 1'b0, 1'b0);
    push_ticks(2, 1'b0, 1'b0);
    repeat (5) homing_run();
    drain();
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("** lift_homing_sequencer: PASSED **");
    end else begin
      $display("** lift_homing_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lhs_pkg.sv
rtl/core/lhs_cfg_regs.sv
rtl/core/lhs_core.sv
rtl/core/lift_homing_sequencer.sv
rtl/core/lhs_checker.sv
tb/tb_lift_homing_sequencer.sv
